### hw/rtl/mcam_pkg.sv
// Shared types, constants and register codes for the multichannel audio mixer.
package mcam_pkg;

    // Fixed geometry
    localparam int NUM_CH     = 4;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 9;
    localparam int LEVEL_W    = 16;
    localparam int STEP_W     = 16;
    localparam int BLEN_W     = 13;
    localparam int BPOS_W     = 12;
    localparam int CFG_DATA_W = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int ROUTE_W    = 2;
    localparam int FMT_W      = 2;
    localparam int DONE_W     = 4;

    // Datapath widths
    localparam int CM_W      = 17;                       // channel gain * master gain
    localparam int PROD_W    = 32;                       // magnitude * CM
    localparam int CONTRIB_W = 17;                       // signed scaled sample
    localparam int SUM_W     = CONTRIB_W + $clog2(NUM_CH) + 1;

    // Sequencing: 3 multiply stages, one sum stage per cell
    localparam int PIPE_LAST = NUM_CH + 3;
    localparam int CNT_W     = $clog2(PIPE_LAST + 1);

    // Fixed values
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'h8000;
    localparam logic [GAIN_W-1:0]  UNITY_GAIN = 9'd256;
    localparam logic [BLEN_W-1:0]  MAX_BLOCK  = 13'd4096;

    // Register reset values
    localparam logic [GAIN_W-1:0]     RST_MASTER_GAIN = 9'd256;
    localparam logic [CFG_DATA_W-1:0] RST_CH_GAINS    = 36'd34426978560;
    localparam logic [7:0]            RST_ROUTES      = 8'h00;
    localparam logic [7:0]            RST_FORMATS     = 8'hFF;
    localparam logic [STEP_W-1:0]     RST_FADE_STEP   = 16'd655;
    localparam logic [BLEN_W-1:0]     RST_BLOCK_LEN   = 13'd256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CH_GAINS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTES      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMATS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN   = 3'd5;

    // Route codes (stereo is anything else)
    localparam logic [ROUTE_W-1:0] RT_LEFT  = 2'd1;
    localparam logic [ROUTE_W-1:0] RT_RIGHT = 2'd2;

    // Format bits
    localparam int FMT_STEREO = 0;
    localparam int FMT_WIDE   = 1;

    typedef logic signed [SUM_W-1:0]     t_sum;
    typedef logic signed [CONTRIB_W-1:0] t_contrib;

    typedef struct packed {
        logic load;
        logic active;
        logic start;
        logic block_end;
    } t_cell_ctrl;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [GAIN_W-1:0]  master;     // already limited to unity
        logic [ROUTE_W-1:0] route;
        logic [FMT_W-1:0]   fmt;
        logic [STEP_W-1:0]  fade_step;
    } t_cell_cfg;

endpackage

### hw/rtl/multichannel_audio_mixer_unit.sv
// Top level of the four-channel PCM mixer: config, sequencing, cell chain, output.
//
//  channel   signals                                   direction
//  -------   ---------------------------------------   ---------
//  input     i_in_valid / o_in_ready, lanes, masks     in
//  output    o_out_valid / i_out_ready, left/right     out
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata          in
//
// Each request passes three multiply stages inside every cell, then the
// partial sums ripple down the cell chain one cell per clock, then the soft
// clip loads the output register. One request at a time.
// Reset is synchronous, active low; it restores register defaults, full fade
// level, no fading channels and block position zero. A stalled output holds
// the finished request; a new request is taken while the result waits.
module multichannel_audio_mixer_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input requests
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mcam_pkg::SAMPLE_W-1:0]        i_lane0_first,
    input  logic [mcam_pkg::SAMPLE_W-1:0]        i_lane0_second,
    input  logic [mcam_pkg::SAMPLE_W-1:0]        i_lane1_first,
    input  logic [mcam_pkg::SAMPLE_W-1:0]        i_lane1_second,
    input  logic [mcam_pkg::SAMPLE_W-1:0]        i_lane2_first,
    input  logic [mcam_pkg::SAMPLE_W-1:0]        i_lane2_second,
    input  logic [mcam_pkg::SAMPLE_W-1:0]        i_lane3_first,
    input  logic [mcam_pkg::SAMPLE_W-1:0]        i_lane3_second,
    input  logic [mcam_pkg::NUM_CH-1:0]          i_active_mask,
    input  logic [mcam_pkg::NUM_CH-1:0]          i_fade_start_mask,
    // output requests
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [mcam_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [mcam_pkg::SAMPLE_W-1:0] o_right_out,
    output logic [mcam_pkg::DONE_W-1:0]          o_fade_done_mask,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [mcam_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mcam_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    // Configuration registers
    logic [mcam_pkg::GAIN_W-1:0]     r_master_gain;
    logic [mcam_pkg::CFG_DATA_W-1:0] r_ch_gains;
    logic [7:0]                      r_routes;
    logic [7:0]                      r_formats;
    logic [mcam_pkg::STEP_W-1:0]     r_fade_step;
    logic [mcam_pkg::BLEN_W-1:0]     r_block_len;

    // Sequencing
    logic                            r_busy;
    logic [mcam_pkg::CNT_W-1:0]      r_cnt;
    logic [mcam_pkg::BPOS_W-1:0]     r_block_pos;
    logic                            w_in_acc, w_out_acc, w_finish;
    logic [mcam_pkg::BLEN_W-1:0]     w_len;
    logic                            w_block_end;
    logic [mcam_pkg::GAIN_W-1:0]     w_master;

    // Output register
    logic                                 r_out_valid;
    logic signed [mcam_pkg::SAMPLE_W-1:0] r_left_out, r_right_out;
    logic [mcam_pkg::DONE_W-1:0]          r_done_mask;
    logic signed [mcam_pkg::SAMPLE_W-1:0] w_left_clip, w_right_clip;

    // Chain wiring
    logic [mcam_pkg::SAMPLE_W-1:0]   w_first  [mcam_pkg::NUM_CH];
    logic [mcam_pkg::SAMPLE_W-1:0]   w_second [mcam_pkg::NUM_CH];
    mcam_pkg::t_sum                  w_sum_l  [mcam_pkg::NUM_CH+1];
    mcam_pkg::t_sum                  w_sum_r  [mcam_pkg::NUM_CH+1];
    logic [mcam_pkg::NUM_CH-1:0]     w_done;

    assign w_first[0]  = i_lane0_first;
    assign w_second[0] = i_lane0_second;
    assign w_first[1]  = i_lane1_first;
    assign w_second[1] = i_lane1_second;
    assign w_first[2]  = i_lane2_first;
    assign w_second[2] = i_lane2_second;
    assign w_first[3]  = i_lane3_first;
    assign w_second[3] = i_lane3_second;

    // Config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_gain <= mcam_pkg::RST_MASTER_GAIN;
            r_ch_gains    <= mcam_pkg::RST_CH_GAINS;
            r_routes      <= mcam_pkg::RST_ROUTES;
            r_formats     <= mcam_pkg::RST_FORMATS;
            r_fade_step   <= mcam_pkg::RST_FADE_STEP;
            r_block_len   <= mcam_pkg::RST_BLOCK_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mcam_pkg::CFG_MASTER_GAIN: r_master_gain <= i_cfg_wdata[mcam_pkg::GAIN_W-1:0];
                mcam_pkg::CFG_CH_GAINS:    r_ch_gains    <= i_cfg_wdata;
                mcam_pkg::CFG_ROUTES:      r_routes      <= i_cfg_wdata[7:0];
                mcam_pkg::CFG_FORMATS:     r_formats     <= i_cfg_wdata[7:0];
                mcam_pkg::CFG_FADE_STEP:   r_fade_step   <= i_cfg_wdata[mcam_pkg::STEP_W-1:0];
                mcam_pkg::CFG_BLOCK_LEN:   r_block_len   <= i_cfg_wdata[mcam_pkg::BLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective block length: zero acts as one, capped at 4096
    always_comb begin
        if (r_block_len == '0) begin
            w_len = mcam_pkg::BLEN_W'(1);
        end else if (r_block_len > mcam_pkg::MAX_BLOCK) begin
            w_len = mcam_pkg::MAX_BLOCK;
        end else begin
            w_len = r_block_len;
        end
        w_block_end = (mcam_pkg::BLEN_W'(r_block_pos) + mcam_pkg::BLEN_W'(1)) >= w_len;
        w_master    = (r_master_gain > mcam_pkg::UNITY_GAIN) ? mcam_pkg::UNITY_GAIN
                                                             : r_master_gain;
    end

    // Handshakes. Chain data is recomputed every clock from held captures, so
    // a stalled finish just waits with the final sums stable.
    assign o_in_ready = !r_busy;
    assign w_in_acc   = i_in_valid & !r_busy;
    assign w_out_acc  = r_out_valid & i_out_ready;
    assign w_finish   = r_busy && (r_cnt == mcam_pkg::CNT_W'(mcam_pkg::PIPE_LAST))
                        && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_block_pos <= '0;
        end else begin
            if (w_in_acc) begin
                r_busy      <= 1'b1;
                r_cnt       <= '0;
                r_block_pos <= w_block_end ? '0 : (r_block_pos + mcam_pkg::BPOS_W'(1));
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end else if (r_busy && (r_cnt != mcam_pkg::CNT_W'(mcam_pkg::PIPE_LAST))) begin
                r_cnt <= r_cnt + mcam_pkg::CNT_W'(1);
            end
        end
    end

    // Cell chain
    assign w_sum_l[0] = '0;
    assign w_sum_r[0] = '0;

    for (genvar c = 0; c < mcam_pkg::NUM_CH; c++) begin : g_cell
        mcam_pkg::t_cell_ctrl w_ctrl;
        mcam_pkg::t_cell_cfg  w_cfg;

        always_comb begin
            w_ctrl.load      = w_in_acc;
            w_ctrl.active    = i_active_mask[c];
            w_ctrl.start     = i_fade_start_mask[c];
            w_ctrl.block_end = w_block_end;
            w_cfg.gain       = r_ch_gains[c*mcam_pkg::GAIN_W +: mcam_pkg::GAIN_W];
            w_cfg.master     = w_master;
            w_cfg.route      = r_routes[c*mcam_pkg::ROUTE_W +: mcam_pkg::ROUTE_W];
            w_cfg.fmt        = r_formats[c*mcam_pkg::FMT_W +: mcam_pkg::FMT_W];
            w_cfg.fade_step  = r_fade_step;
        end

        mcam_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_cfg    (w_cfg),
            .i_first  (w_first[c]),
            .i_second (w_second[c]),
            .i_sum_l  (w_sum_l[c]),
            .i_sum_r  (w_sum_r[c]),
            .o_sum_l  (w_sum_l[c+1]),
            .o_sum_r  (w_sum_r[c+1]),
            .o_done   (w_done[c])
        );
    end

    // Soft clip on the chain end
    mcam_softclip u_clip_l (
        .i_sum    (w_sum_l[mcam_pkg::NUM_CH]),
        .o_sample (w_left_clip)
    );

    mcam_softclip u_clip_r (
        .i_sum    (w_sum_r[mcam_pkg::NUM_CH]),
        .o_sample (w_right_clip)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_left_out  <= w_left_clip;
            r_right_out <= w_right_clip;
            r_done_mask <= w_done[mcam_pkg::DONE_W-1:0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_left_out       = r_left_out;
    assign o_right_out      = r_right_out;
    assign o_fade_done_mask = r_done_mask;

endmodule

### hw/rtl/mcam_cell.sv
// One mixer channel cell: fade state, decode, scale and running-sum stage.
module mcam_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mcam_pkg::t_cell_ctrl                 i_ctrl,
    input  mcam_pkg::t_cell_cfg                  i_cfg,
    input  logic [mcam_pkg::SAMPLE_W-1:0]        i_first,
    input  logic [mcam_pkg::SAMPLE_W-1:0]        i_second,
    input  mcam_pkg::t_sum                       i_sum_l,
    input  mcam_pkg::t_sum                       i_sum_r,
    output mcam_pkg::t_sum                       o_sum_l,
    output mcam_pkg::t_sum                       o_sum_r,
    output logic                                 o_done
);

    function automatic logic signed [mcam_pkg::SAMPLE_W-1:0] decode(
        input logic [mcam_pkg::SAMPLE_W-1:0] raw,
        input logic                          wide
    );
        if (wide) begin
            return $signed(raw);
        end
        // (byte - 128) * 256
        return $signed({~raw[7], raw[6:0], 8'h00});
    endfunction

    // Fade state
    logic                              r_fade_act, n_fade_act;
    logic [mcam_pkg::LEVEL_W-1:0]      r_fade_lev, n_fade_lev;

    // Per-request capture
    logic [mcam_pkg::SAMPLE_W-1:0]     r_first, r_second;
    logic                              r_active;
    logic                              r_done, n_done;
    logic [mcam_pkg::LEVEL_W-1:0]      r_use_lev, n_use_lev;

    // Fade update
    logic                              w_start_now, w_act_now;
    logic [mcam_pkg::LEVEL_W-1:0]      w_lev_now, w_dec;

    // Stage 1
    logic signed [mcam_pkg::SAMPLE_W-1:0] w_sl, w_sr;
    logic [mcam_pkg::SAMPLE_W-1:0]     w_mag_l, w_mag_r;
    logic [mcam_pkg::GAIN_W-1:0]       w_cg;
    logic [mcam_pkg::CM_W-1:0]         w_cm;
    logic [mcam_pkg::SAMPLE_W-1:0]     r_mag_l, r_mag_r;
    logic                              r_neg1_l, r_neg1_r;
    logic [mcam_pkg::CM_W-1:0]         r_cm;

    // Stage 2
    logic [mcam_pkg::PROD_W:0]         w_p_l, w_p_r;
    logic [mcam_pkg::PROD_W-1:0]       r_p_l, r_p_r;
    logic                              r_neg2_l, r_neg2_r;

    // Stage 3
    logic [47:0]                       w_q_l, w_q_r;
    mcam_pkg::t_contrib                w_cq_l, w_cq_r;
    logic                              w_en_l, w_en_r;
    mcam_pkg::t_contrib                r_c_l, r_c_r;

    // Sum stage
    mcam_pkg::t_sum                    r_sum_l, r_sum_r;

    // Fade bookkeeping done at load time
    always_comb begin
        w_start_now = i_ctrl.active & i_ctrl.start;
        w_act_now   = r_fade_act | w_start_now;
        w_lev_now   = w_start_now ? mcam_pkg::FULL_LEVEL : r_fade_lev;
        n_use_lev   = w_act_now ? w_lev_now : mcam_pkg::FULL_LEVEL;
        w_dec       = (w_lev_now > i_cfg.fade_step) ? (w_lev_now - i_cfg.fade_step) : '0;
        n_fade_act  = w_act_now;
        n_fade_lev  = w_lev_now;
        n_done      = 1'b0;
        if (i_ctrl.block_end && w_act_now) begin
            if (w_dec == '0) begin
                n_done     = 1'b1;
                n_fade_act = 1'b0;
                n_fade_lev = mcam_pkg::FULL_LEVEL;
            end else begin
                n_fade_lev = w_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_act <= 1'b0;
            r_fade_lev <= mcam_pkg::FULL_LEVEL;
        end else if (i_ctrl.load) begin
            r_fade_act <= n_fade_act;
            r_fade_lev <= n_fade_lev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_first   <= i_first;
            r_second  <= i_second;
            r_active  <= i_ctrl.active;
            r_done    <= n_done;
            r_use_lev <= n_use_lev;
        end
    end

    // Stage 1: decode, magnitude, gain product
    always_comb begin
        w_sl    = decode(r_first, i_cfg.fmt[mcam_pkg::FMT_WIDE]);
        w_sr    = i_cfg.fmt[mcam_pkg::FMT_STEREO] ?
                  decode(r_second, i_cfg.fmt[mcam_pkg::FMT_WIDE]) : w_sl;
        w_mag_l = w_sl[mcam_pkg::SAMPLE_W-1] ? mcam_pkg::SAMPLE_W'(-w_sl)
                                             : mcam_pkg::SAMPLE_W'(w_sl);
        w_mag_r = w_sr[mcam_pkg::SAMPLE_W-1] ? mcam_pkg::SAMPLE_W'(-w_sr)
                                             : mcam_pkg::SAMPLE_W'(w_sr);
        w_cg    = (i_cfg.gain > mcam_pkg::UNITY_GAIN) ? mcam_pkg::UNITY_GAIN : i_cfg.gain;
        w_cm    = mcam_pkg::CM_W'(w_cg) * mcam_pkg::CM_W'(i_cfg.master);
    end

    always_ff @(posedge i_clk) begin
        r_mag_l  <= w_mag_l;
        r_mag_r  <= w_mag_r;
        r_neg1_l <= w_sl[mcam_pkg::SAMPLE_W-1];
        r_neg1_r <= w_sr[mcam_pkg::SAMPLE_W-1];
        r_cm     <= w_cm;
    end

    // Stage 2: magnitude * (channel gain * master gain), max 2^31
    assign w_p_l = (mcam_pkg::PROD_W+1)'(r_mag_l) * (mcam_pkg::PROD_W+1)'(r_cm);
    assign w_p_r = (mcam_pkg::PROD_W+1)'(r_mag_r) * (mcam_pkg::PROD_W+1)'(r_cm);

    always_ff @(posedge i_clk) begin
        r_p_l    <= w_p_l[mcam_pkg::PROD_W-1:0];
        r_p_r    <= w_p_r[mcam_pkg::PROD_W-1:0];
        r_neg2_l <= r_neg1_l;
        r_neg2_r <= r_neg1_r;
    end

    // Stage 3: times fade level, drop Q31 fraction, restore sign
    always_comb begin
        w_q_l  = 48'(r_p_l) * 48'(r_use_lev);
        w_q_r  = 48'(r_p_r) * 48'(r_use_lev);
        w_cq_l = $signed({1'b0, w_q_l[46:31]});
        w_cq_r = $signed({1'b0, w_q_r[46:31]});
        w_en_l = r_active & (i_cfg.route != mcam_pkg::RT_RIGHT);
        w_en_r = r_active & (i_cfg.route != mcam_pkg::RT_LEFT);
    end

    always_ff @(posedge i_clk) begin
        r_c_l <= w_en_l ? (r_neg2_l ? -w_cq_l : w_cq_l) : '0;
        r_c_r <= w_en_r ? (r_neg2_r ? -w_cq_r : w_cq_r) : '0;
    end

    // Running sum handed to the next cell
    always_ff @(posedge i_clk) begin
        r_sum_l <= i_sum_l + $signed({{(mcam_pkg::SUM_W-mcam_pkg::CONTRIB_W){r_c_l[mcam_pkg::CONTRIB_W-1]}},
                                      r_c_l});
        r_sum_r <= i_sum_r + $signed({{(mcam_pkg::SUM_W-mcam_pkg::CONTRIB_W){r_c_r[mcam_pkg::CONTRIB_W-1]}},
                                      r_c_r});
    end

    assign o_sum_l = r_sum_l;
    assign o_sum_r = r_sum_r;
    assign o_done  = r_done;

endmodule

### hw/rtl/mcam_softclip.sv
// Soft clip (excess over full scale divided by 8) followed by 16-bit saturation.
module mcam_softclip (
    input  mcam_pkg::t_sum                       i_sum,
    output logic signed [mcam_pkg::SAMPLE_W-1:0] o_sample
);

    localparam mcam_pkg::t_sum HI = mcam_pkg::t_sum'(32767);
    localparam mcam_pkg::t_sum LO = mcam_pkg::t_sum'(-32768);

    mcam_pkg::t_sum w_soft;

    always_comb begin
        w_soft = i_sum;
        if (i_sum > HI) begin
            w_soft = HI + ((i_sum - HI) >>> 3);
        end else if (i_sum < LO) begin
            w_soft = LO - ((LO - i_sum) >>> 3);
        end
        if (w_soft > HI) begin
            o_sample = HI[mcam_pkg::SAMPLE_W-1:0];
        end else if (w_soft < LO) begin
            o_sample = LO[mcam_pkg::SAMPLE_W-1:0];
        end else begin
            o_sample = w_soft[mcam_pkg::SAMPLE_W-1:0];
        end
    end

endmodule
